### rtl/extended_euclid_gcd_defines.svh
// Assertion macros for the extended Euclid GCD block.
`ifndef EXTENDED_EUCLID_GCD_DEFINES_SVH
`define EXTENDED_EUCLID_GCD_DEFINES_SVH
`ifndef SYNTHESIS
`define EEG_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");
`define EEG_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");
`else
`define EEG_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define EEG_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

### rtl/eeg_pkg.sv
// Shared types for the extended Euclid GCD block.
package eeg_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_DIV,
		ST_MUL,
		ST_UPD,
		ST_OUT
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic mul_step;
		logic update;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic cur_zero;
		logic div_last;
		logic mul_last;
	} status_t;

endpackage

### rtl/eeg_datapath.sv
// Datapath: remainder pair, coefficients, shift-subtract divider, serial multiplier.
module eeg_datapath #(
	parameter int W = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  eeg_pkg::cmd_t      cmd,
	input  logic [W-1:0]       in_a,
	input  logic [W-1:0]       in_b,
	output eeg_pkg::status_t   status,
	output logic [W-1:0]       gcd_out,
	output logic [W:0]         x_out,
	output logic [W:0]         y_out
);
	localparam int CW = $clog2(W);

	logic [W-1:0] r_prev_q, r_cur_q;
	logic [W:0]   ka_prev_q, ka_cur_q, kb_prev_q, kb_cur_q;
	logic [W-1:0] quot_q, rem_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]   pa_q, pb_q;

	logic [W:0] trial;
	assign trial = {rem_q, quot_q[W-1]} - {1'b0, r_cur_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= CW'(W - 1);
		end else if ((cmd.div_step || cmd.mul_step) && cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end else if (cmd.div_step) begin
			cnt_q <= CW'(W - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_prev_q  <= in_b;
			r_cur_q   <= in_a;
			kb_prev_q <= (W+1)'(1);
			ka_prev_q <= '0;
			kb_cur_q  <= '0;
			ka_cur_q  <= (W+1)'(1);
		end
		// restoring division, one quotient bit a cycle
		if (cmd.div_start) begin
			quot_q <= r_prev_q;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			if (!trial[W]) begin
				rem_q  <= trial[W-1:0];
				quot_q <= {quot_q[W-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[W-2:0], quot_q[W-1]};
				quot_q <= {quot_q[W-2:0], 1'b0};
			end
		end
		// serial multiply q*k, accumulate products modulo 2^(W+1)
		if (cmd.div_step && cnt_q == '0) begin
			pa_q <= '0;
			pb_q <= '0;
		end else if (cmd.mul_step) begin
			pa_q <= (pa_q << 1) + (quot_q[cnt_q] ? ka_cur_q : '0);
			pb_q <= (pb_q << 1) + (quot_q[cnt_q] ? kb_cur_q : '0);
		end
		if (cmd.update) begin
			r_prev_q  <= r_cur_q;
			r_cur_q   <= rem_q;
			ka_prev_q <= ka_cur_q;
			ka_cur_q  <= ka_prev_q - pa_q;
			kb_prev_q <= kb_cur_q;
			kb_cur_q  <= kb_prev_q - pb_q;
		end
	end

	assign status.cur_zero = (r_cur_q == '0);
	assign status.div_last = (cnt_q == '0);
	assign status.mul_last = (cnt_q == '0);
	assign gcd_out = r_prev_q;
	assign x_out   = ka_prev_q;
	assign y_out   = kb_prev_q;
endmodule

### rtl/eeg_ctrl.sv
// Controller: sequences load, divide, multiply and update steps.
`include "extended_euclid_gcd_defines.svh"
module eeg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  eeg_pkg::status_t status,
	output eeg_pkg::cmd_t    cmd
);
	eeg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= eeg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			eeg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = eeg_pkg::ST_CHK;
				end
			end
			// done once the current remainder is zero
			eeg_pkg::ST_CHK: begin
				if (status.cur_zero) begin
					state_d = eeg_pkg::ST_OUT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = eeg_pkg::ST_DIV;
				end
			end
			eeg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = eeg_pkg::ST_MUL;
			end
			eeg_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.mul_last) state_d = eeg_pkg::ST_UPD;
			end
			// commit the step, then check the new remainder
			eeg_pkg::ST_UPD: begin
				cmd.update = 1'b1;
				state_d = eeg_pkg::ST_CHK;
			end
			eeg_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = eeg_pkg::ST_IDLE;
			end
			default: state_d = eeg_pkg::ST_IDLE;
		endcase
	end

	`EEG_ASSERT_IMP(a_rdy_idle, clk, arst_n, in_ready, state_q == eeg_pkg::ST_IDLE)
	`EEG_ASSERT_IMP(a_excl, clk, arst_n, out_valid, !in_ready)
	`EEG_ASSERT_NEXT(a_load, clk, arst_n, in_valid && in_ready, state_q == eeg_pkg::ST_CHK)
	`EEG_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

### rtl/extended_euclid_gcd.sv
// Top level of the extended Euclid GCD block.
// Takes operands a, b; returns gcd g and Bezout x, y (OPERAND_WIDTH+1-bit two's complement)
// with x*a + y*b = g. One item at a time: s_tready is high only while idle. Each Euclid step
// is a check of the remainder, a one-bit-per-cycle restoring divider, a one-bit-per-cycle
// serial multiply of the quotient into both coefficients, then an update. a = 0 needs no
// step; at most about 46 steps for W=32.
module extended_euclid_gcd #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]  s_tdata,  // operand_a, operand_b
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((3*OPERAND_WIDTH+9)/8)*8-1:0]  m_tdata   // gcd_value, coeff_x, coeff_y
);
	localparam int W = OPERAND_WIDTH;
	localparam int OUT_BITS = ((3*OPERAND_WIDTH+9)/8)*8;
	eeg_pkg::cmd_t cmd;
	eeg_pkg::status_t status;
	logic [W-1:0] g;
	logic [W:0] x, y;

	eeg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .status(status), .cmd(cmd)
	);

	eeg_datapath #(.W(W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_a(s_tdata[W-1:0]), .in_b(s_tdata[2*W-1:W]),
		.status(status), .gcd_out(g), .x_out(x), .y_out(y)
	);

	assign m_tdata = OUT_BITS'({y, x, g});
endmodule

### tb/extended_euclid_gcd_checker.sv
// Checker for the extended Euclid GCD block: predicts each result from the accepted operands.
module extended_euclid_gcd_checker #(
	parameter int W = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [2*W-1:0]               s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [((3*W+9)/8)*8-1:0]     m_tdata,
	output int                           fail_count,
	output int                           pending_count
);

	typedef struct packed {
		logic [W-1:0] g;
		logic [W:0]   x;
		logic [W:0]   y;
	} bezout_t;

	bezout_t gcd_queue[$];

	// Iterative extended Euclid on (b, a); coefficients wrap at W+1 bits
	function automatic bezout_t solve_bezout(logic [W-1:0] a, logic [W-1:0] b);
		logic [W-1:0] r_prev, r_cur, r_next, q;
		logic [W:0]   kb_prev, ka_prev, kb_cur, ka_cur, kb_next, ka_next;
		bezout_t      res;
		r_prev = b;
		r_cur = a;
		kb_prev = 1;
		ka_prev = 0;
		kb_cur = 0;
		ka_cur = 1;
		for (int i = 0; i < 3 * W + 8 && r_cur != 0; i++) begin
			q = r_prev / r_cur;
			r_next = r_prev - q * r_cur;
			kb_next = kb_prev - (W+1)'(q) * kb_cur;
			ka_next = ka_prev - (W+1)'(q) * ka_cur;
			r_prev = r_cur;
			r_cur = r_next;
			kb_prev = kb_cur;
			kb_cur = kb_next;
			ka_prev = ka_cur;
			ka_cur = ka_next;
		end
		res.g = r_prev;
		res.x = ka_prev;
		res.y = kb_prev;
		return res;
	endfunction

	assign pending_count = gcd_queue.size();

	// Predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		bezout_t want, got;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				gcd_queue.push_back(solve_bezout(s_tdata[W-1:0], s_tdata[2*W-1:W]));
			if (m_tvalid && m_tready) begin
				got.g = m_tdata[W-1:0];
				got.x = m_tdata[2*W:W];
				got.y = m_tdata[3*W+1:2*W+1];
				if (gcd_queue.size() == 0) begin
					$display("%0t: unexpected result g=%h x=%h y=%h", $time,
						got.g, got.x, got.y);
					errs++;
				end else begin
					want = gcd_queue.pop_front();
					if (want.g !== got.g) begin
						$display("%0t: gcd expected %h actual %h", $time, want.g, got.g);
						errs++;
					end
					if (want.x !== got.x) begin
						$display("%0t: coeff_x expected %h actual %h", $time, want.x, got.x);
						errs++;
					end
					if (want.y !== got.y) begin
						$display("%0t: coeff_y expected %h actual %h", $time, want.y, got.y);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end

endmodule

### tb/extended_euclid_gcd_tb.sv
// Testbench top for the extended Euclid GCD block: operand stimulus, stalls and verdict.
module extended_euclid_gcd_tb;

	localparam int W = 32;
	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_OFF_CYCLES = 2000;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [2*W-1:0]               s_tdata = '0;   // operand_a, operand_b
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [((3*W+9)/8)*8-1:0]     m_tdata;        // gcd_value, coeff_x, coeff_y
	int                           fail_count;
	int                           pending_count;
	bit                           calm_phase = 1'b0;
	int                           idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	extended_euclid_gcd #(.OPERAND_WIDTH(W)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	extended_euclid_gcd_checker #(.W(W)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	function automatic logic [W-1:0] rand_operand();
		logic [W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 15);
			1: v = $urandom_range(0, 1000);
			2: v = ~W'($urandom_range(0, 15));
			3: v = W'(1) << $urandom_range(0, W - 1);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Offer one operand pair at the falling edge and hold until accepted
	task automatic send_pair(logic [W-1:0] a, logic [W-1:0] b);
		s_tdata <= {b, a};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		if (!calm_phase && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	endtask

	// Receiver: one long hold-off early, then random stall bursts
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		m_tready <= 1'b0;
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		forever begin
			if (!calm_phase && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [W-1:0] a, b;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// Directed: zeros, equal operands, extremes, coprime and Fibonacci worst case
		send_pair(0, 0);
		send_pair(0, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 0);
		send_pair(5, 0);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pair(17, 17);
		send_pair(1, 32'hFFFF_FFFF);
		send_pair(32'hFFFF_FFFF, 1);
		send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF);
		send_pair(240, 46);
		send_pair(46, 240);
		send_pair(32'd1836311903, 32'd2971215073);
		send_pair(32'd2971215073, 32'd1836311903);
		send_pair(32'hAAAA_AAAA, 32'h5555_5555);
		send_pair(32'h5555_5555, 32'hAAAA_AAAA);
		send_pair(12, 18);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - 40)
				calm_phase = 1'b1;
			a = rand_operand();
			case ($urandom_range(0, 7))
				0: b = a;
				1: b = a * $urandom_range(1, 9);
				default: b = rand_operand();
			endcase
			send_pair(a, b);
			sender_gap();
		end
		s_tvalid <= 1'b0;
		while (pending_count != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
